// ===== design/ptw_pkg.sv =====
package ptw_pkg;

  localparam int unsigned VA_W   = 48;
  localparam int unsigned PA_W   = 52;
  localparam int unsigned DATA_W = 64;

  // Configuration register indexes
  localparam logic [2:0] CFG_CR3 = 3'd0;
  localparam logic [2:0] CFG_LM  = 3'd1;
  localparam logic [2:0] CFG_PAE = 3'd2;
  localparam logic [2:0] CFG_PSE = 3'd3;
  localparam logic [2:0] CFG_NXE = 3'd4;
  localparam logic [2:0] CFG_NXA = 3'd5;

  // Input item opcodes
  localparam logic OP_START    = 1'b0;
  localparam logic OP_RESPONSE = 1'b1;

  // Result item kinds
  localparam logic [2:0] KIND_READ  = 3'd0;
  localparam logic [2:0] KIND_WRITE = 3'd1;
  localparam logic [2:0] KIND_FILL  = 3'd2;
  localparam logic [2:0] KIND_NP    = 3'd3;
  localparam logic [2:0] KIND_NX    = 3'd4;

  // Fill page sizes
  localparam logic [1:0] PSZ_4K = 2'd0;
  localparam logic [1:0] PSZ_2M = 2'd1;
  localparam logic [1:0] PSZ_4M = 2'd2;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [2:0]        kind;
    logic [PA_W-1:0]   mem_address;
    logic [DATA_W-1:0] mem_data;
    logic              wide_access;
    logic              uncacheable;
    logic [1:0]        page_size;
    logic              writable;
    logic              user_access;
    logic              no_exec;
    logic              global_page;
    logic              pat_bit;
    logic              last;
  } res_t;

  // Everything one accepted input item gives: one result, or a read plus a write-back.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } rec_t;

  // Queue status (has an entry, has space) for the back end and in_ready.
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

// ===== design/x86_page_table_walk_unit.sv =====
// x86 page table walker for long (4-level), PAE (3-level) and legacy (2-level,
// optional 4M PSE pages) paging. Send a start item (opcode 0) with a virtual
// address to get the root entry read request; send each read response as an
// opcode 1 item. Each response gives either the next read (plus an
// accessed-bit write-back when A was clear), a TLB fill, or a not-present or
// NX fault; the last result of an item has out_last set. A start item during
// a walk, or a response while idle, is dropped with no result. Program the
// cfg registers only while idle. Rate: one input item per cycle while the queue
// has space; the front end classifies an item in its accept cycle and queues its
// results in a two-entry record queue, and the output stage sends one result per
// cycle while out_ready is high, so an item with a write-back occupies the output
// for two results, and in_ready drops only when the queue is full. The first
// result reaches the output through the queue and the output register.
module x86_page_table_walk_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration writes
  input  logic                        cfg_write_enable,
  input  logic [2:0]                  cfg_index,
  input  logic [ptw_pkg::DATA_W-1:0]  cfg_data,
  // input items
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_opcode,
  input  logic [ptw_pkg::VA_W-1:0]    in_virtual_address,
  input  logic [ptw_pkg::DATA_W-1:0]  in_read_data,
  // result items
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_kind,
  output logic [ptw_pkg::PA_W-1:0]    out_mem_address,
  output logic [ptw_pkg::DATA_W-1:0]  out_mem_data,
  output logic                        out_wide_access,
  output logic                        out_uncacheable,
  output logic [1:0]                  out_page_size,
  output logic                        out_writable,
  output logic                        out_user_access,
  output logic                        out_no_exec,
  output logic                        out_global_page,
  output logic                        out_pat_bit,
  output logic                        out_last
);

  logic          in_accept;
  logic          push_valid;
  ptw_pkg::rec_t push_rec;
  ptw_pkg::hs_t  q_st;
  ptw_pkg::rec_t q_rec;
  logic          pop;
  ptw_pkg::res_t res;

  // ready only depends on queue space, never on the walk state
  assign in_ready  = q_st.ready;
  assign in_accept = in_valid && in_ready;

  ptw_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write_enable   (cfg_write_enable),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_accept          (in_accept),
    .in_opcode          (in_opcode),
    .in_virtual_address (in_virtual_address),
    .in_read_data       (in_read_data),
    .push_valid         (push_valid),
    .push_rec           (push_rec)
  );

  ptw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_valid),
    .push_rec (push_rec),
    .pop      (pop),
    .st       (q_st),
    .head_rec (q_rec)
  );

  ptw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_st      (q_st),
    .q_rec     (q_rec),
    .pop       (pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign out_kind        = res.kind;
  assign out_mem_address = res.mem_address;
  assign out_mem_data    = res.mem_data;
  assign out_wide_access = res.wide_access;
  assign out_uncacheable = res.uncacheable;
  assign out_page_size   = res.page_size;
  assign out_writable    = res.writable;
  assign out_user_access = res.user_access;
  assign out_no_exec     = res.no_exec;
  assign out_global_page = res.global_page;
  assign out_pat_bit     = res.pat_bit;
  assign out_last        = res.last;

endmodule

// ===== design/ptw_front.sv =====
module ptw_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_write_enable,
  input  logic [2:0]                    cfg_index,
  input  logic [ptw_pkg::DATA_W-1:0]    cfg_data,
  input  logic                          in_accept,
  input  logic                          in_opcode,
  input  logic [ptw_pkg::VA_W-1:0]      in_virtual_address,
  input  logic [ptw_pkg::DATA_W-1:0]    in_read_data,
  output logic                          push_valid,
  output ptw_pkg::rec_t                 push_rec
);

  typedef enum logic [3:0] {
    LV_IDLE = 4'd0,
    LV_L4   = 4'd1,
    LV_L3   = 4'd2,
    LV_L2   = 4'd3,
    LV_L1   = 4'd4,
    LV_P3   = 4'd5,
    LV_P2   = 4'd6,
    LV_P1   = 4'd7,
    LV_PSE  = 4'd8,
    LV_PD   = 4'd9,
    LV_PT   = 4'd10
  } level_t;

  logic [63:0] cr3_r;
  logic        lm_r, pae_r, pse_r, nxe_r, nxa_r;

  level_t                     level_r, level_nxt;
  logic [ptw_pkg::PA_W-1:0]   eaddr_r, eaddr_nxt;
  logic [ptw_pkg::VA_W-1:0]   va_r, va_nxt;
  logic                       accw_r, accw_nxt;
  logic                       accu_r, accu_nxt;
  logic                       accnx_r, accnx_nxt;
  logic                       wide_r, wide_nxt;
  logic                       eunc_r, eunc_nxt;

  logic                       idle;
  logic [63:0]                pte;
  logic                       p, w, u, pcd, a, ps, g, nx, bad, dowr, nx_check;
  logic [ptw_pkg::PA_W-1:0]   nxt;
  level_t                     nlv;
  logic                       has_res;
  ptw_pkg::rec_t              rec;

  assign idle = (level_r == LV_IDLE) || (level_r > LV_PT);
  assign pte  = wide_r ? in_read_data : {32'd0, in_read_data[31:0]};
  assign p    = pte[0];
  assign w    = pte[1];
  assign u    = pte[2];
  assign pcd  = pte[4];
  assign a    = pte[5];
  assign ps   = pte[7];
  assign g    = pte[8];
  assign nx   = pte[63];
  assign bad  = nx && !(nxa_r && nxe_r);
  assign nx_check = (level_r <= LV_L1) || (level_r == LV_P2) || (level_r == LV_P1);
  assign dowr = (level_r != LV_P3) && !a;

  always_comb begin
    level_nxt = level_r;
    eaddr_nxt = eaddr_r;
    va_nxt    = va_r;
    accw_nxt  = accw_r;
    accu_nxt  = accu_r;
    accnx_nxt = accnx_r;
    wide_nxt  = wide_r;
    eunc_nxt  = eunc_r;
    has_res   = 1'b0;
    nxt       = '0;
    nlv       = LV_IDLE;
    rec       = '0;
    if (in_opcode == ptw_pkg::OP_START) begin
      if (idle) begin
        has_res   = 1'b1;
        va_nxt    = in_virtual_address;
        accw_nxt  = 1'b0;
        accu_nxt  = 1'b0;
        accnx_nxt = 1'b0;
        wide_nxt  = 1'b1;
        if (lm_r) begin
          level_nxt = LV_L4;
          eaddr_nxt = {cr3_r[51:12], in_virtual_address[47:39], 3'b000};
        end else if (pae_r) begin
          level_nxt = LV_P3;
          eaddr_nxt = {20'd0, cr3_r[31:5], in_virtual_address[31:30], 3'b000};
        end else begin
          wide_nxt  = 1'b0;
          level_nxt = pse_r ? LV_PSE : LV_PD;
          eaddr_nxt = {20'd0, cr3_r[31:12], in_virtual_address[31:22], 2'b00};
        end
        eunc_nxt = cr3_r[4];
        rec.r0.kind        = ptw_pkg::KIND_READ;
        rec.r0.mem_address = eaddr_nxt;
        rec.r0.wide_access = wide_nxt;
        rec.r0.uncacheable = eunc_nxt;
        rec.r0.last        = 1'b1;
      end
    end else if (!idle) begin
      has_res = 1'b1;
      // fault record is the default shape; fills and reads overwrite it
      rec.r0.mem_address = eaddr_r;
      rec.r0.mem_data    = {16'd0, va_r};
      rec.r0.wide_access = wide_r;
      rec.r0.last        = 1'b1;
      if (nx_check && bad) begin
        rec.r0.kind = ptw_pkg::KIND_NX;
        level_nxt   = LV_IDLE;
      end else if (!p) begin
        rec.r0.kind = ptw_pkg::KIND_NP;
        level_nxt   = LV_IDLE;
      end else begin
        case (level_r)
          LV_L4, LV_P2, LV_PSE, LV_PD: begin
            accw_nxt = w;
            accu_nxt = u;
          end
          LV_P3: begin
          end
          default: begin
            accw_nxt = accw_r && w;
            accu_nxt = accu_r && u;
          end
        endcase
        if (level_r == LV_L4) begin
          accnx_nxt = nx;
        end
        rec.r0.uncacheable = pcd;
        rec.r0.writable    = accw_nxt;
        rec.r0.user_access = accu_nxt;
        rec.r0.no_exec     = accnx_nxt;
        rec.r0.global_page = g;
        level_nxt = LV_IDLE;
        case (level_r)
          LV_L4: begin
            nxt = {pte[51:12], va_r[38:30], 3'b000};
            nlv = LV_L3;
          end
          LV_L3, LV_P3: begin
            nxt = {pte[51:12], va_r[29:21], 3'b000};
            nlv = (level_r == LV_L3) ? LV_L2 : LV_P2;
          end
          LV_L2, LV_P2: begin
            if (ps) begin
              rec.r0.kind        = ptw_pkg::KIND_FILL;
              rec.r0.mem_address = {pte[51:21], 21'd0};
              rec.r0.mem_data    = {16'd0, va_r[47:21], 21'd0};
              rec.r0.page_size   = ptw_pkg::PSZ_2M;
              rec.r0.pat_bit     = pte[12];
            end else begin
              nxt = {pte[51:12], va_r[20:12], 3'b000};
              nlv = (level_r == LV_L2) ? LV_L1 : LV_P1;
            end
          end
          LV_L1, LV_P1: begin
            rec.r0.kind        = ptw_pkg::KIND_FILL;
            rec.r0.mem_address = {pte[51:12], 12'd0};
            rec.r0.mem_data    = {16'd0, va_r[47:12], 12'd0};
            rec.r0.page_size   = ptw_pkg::PSZ_4K;
            rec.r0.pat_bit     = (level_r == LV_L1) ? pte[12] : pte[7];
          end
          LV_PSE, LV_PD: begin
            if (ps && (level_r == LV_PSE)) begin
              rec.r0.kind        = ptw_pkg::KIND_FILL;
              rec.r0.mem_address = {12'd0, pte[20:13], pte[31:22], 22'd0};
              rec.r0.mem_data    = {16'd0, va_r[47:22], 22'd0};
              rec.r0.page_size   = ptw_pkg::PSZ_4M;
              rec.r0.pat_bit     = pte[12];
            end else begin
              nxt = {20'd0, pte[31:12], va_r[21:12], 2'b00};
              nlv = LV_PT;
            end
          end
          default: begin
            rec.r0.kind        = ptw_pkg::KIND_FILL;
            rec.r0.mem_address = {20'd0, pte[31:12], 12'd0};
            rec.r0.mem_data    = {16'd0, va_r[47:12], 12'd0};
            rec.r0.page_size   = ptw_pkg::PSZ_4K;
            rec.r0.pat_bit     = pte[7];
          end
        endcase
        if (nlv != LV_IDLE) begin
          // next-level read, then the accessed-bit write-back if needed
          rec.r0             = '0;
          rec.r0.kind        = ptw_pkg::KIND_READ;
          rec.r0.mem_address = nxt;
          rec.r0.wide_access = wide_r;
          rec.r0.uncacheable = pcd;
          rec.r0.last        = !dowr;
          rec.two            = dowr;
          rec.r1.kind        = ptw_pkg::KIND_WRITE;
          rec.r1.mem_address = eaddr_r;
          rec.r1.mem_data    = pte | 64'h20;
          rec.r1.wide_access = wide_r;
          rec.r1.uncacheable = eunc_r;
          rec.r1.last        = 1'b1;
          eaddr_nxt          = nxt;
          eunc_nxt           = pcd;
          level_nxt          = nlv;
        end
      end
    end
  end

  assign push_valid = in_accept && has_res;
  assign push_rec   = rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr3_r   <= '0;
      lm_r    <= 1'b0;
      pae_r   <= 1'b0;
      pse_r   <= 1'b0;
      nxe_r   <= 1'b0;
      nxa_r   <= 1'b0;
      level_r <= LV_IDLE;
      eaddr_r <= '0;
      va_r    <= '0;
      accw_r  <= 1'b0;
      accu_r  <= 1'b0;
      accnx_r <= 1'b0;
      wide_r  <= 1'b1;
      eunc_r  <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          ptw_pkg::CFG_CR3: cr3_r <= cfg_data;
          ptw_pkg::CFG_LM:  lm_r  <= cfg_data[0];
          ptw_pkg::CFG_PAE: pae_r <= cfg_data[0];
          ptw_pkg::CFG_PSE: pse_r <= cfg_data[0];
          ptw_pkg::CFG_NXE: nxe_r <= cfg_data[0];
          ptw_pkg::CFG_NXA: nxa_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (in_accept) begin
        level_r <= level_nxt;
        eaddr_r <= eaddr_nxt;
        va_r    <= va_nxt;
        accw_r  <= accw_nxt;
        accu_r  <= accu_nxt;
        accnx_r <= accnx_nxt;
        wide_r  <= wide_nxt;
        eunc_r  <= eunc_nxt;
      end
    end
  end

endmodule

// ===== design/ptw_queue.sv =====
module ptw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ptw_pkg::rec_t push_rec,
  input  logic          pop,
  output ptw_pkg::hs_t  st,
  output ptw_pkg::rec_t head_rec
);

  // two-entry FIFO of result records
  ptw_pkg::rec_t mem [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign st.valid = (cnt_r != 2'd0);
  assign st.ready = (cnt_r != 2'd2);
  assign head_rec = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== design/ptw_back.sv =====
module ptw_back (
  input  logic          clk,
  input  logic          rst_n,
  input  ptw_pkg::hs_t  q_st,
  input  ptw_pkg::rec_t q_rec,
  output logic          pop,
  input  logic          out_ready,
  output logic          out_valid,
  output ptw_pkg::res_t out_res
);

  ptw_pkg::rec_t rec_r;
  logic          valid_r;
  logic          idx_r;
  logic          take, done;

  assign take = valid_r && out_ready;
  assign done = take && (idx_r || !rec_r.two);
  assign pop  = q_st.valid && (!valid_r || done);

  assign out_valid = valid_r;
  assign out_res   = idx_r ? rec_r.r1 : rec_r.r0;

  always_ff @(posedge clk) begin
    if (pop) begin
      rec_r <= q_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 1'b0;
    end else if (take && !done) begin
      idx_r <= 1'b1;
    end else if (!valid_r || done) begin
      valid_r <= q_st.valid;
      idx_r   <= 1'b0;
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Walk levels of the predictor; the codes only live inside the testbench.
typedef enum logic [3:0] {
  WALK_IDLE,
  PML4, PDPT, PD_LONG, PT_LONG,        // long mode, four levels
  PAE_PDPT, PAE_PD, PAE_PT,            // PAE, three levels
  LEG_PSE_PD, LEG_PD, LEG_PT           // legacy, two levels
} walk_level_e;

localparam int NUM_REGS       = 6;

localparam logic [63:0] FRAME40      = 64'h000F_FFFF_FFFF_F000;
localparam logic [63:0] FRAME2M      = 64'h000F_FFFF_FFE0_0000;
localparam logic [63:0] FRAME20      = 64'h0000_0000_FFFF_F000;
localparam logic [63:0] PAE_DIR_BASE = 64'h0000_0000_FFFF_FFE0;
localparam logic [63:0] SIZE_4K      = 64'h0000_0000_0000_1000;
localparam logic [63:0] SIZE_2M      = 64'h0000_0000_0020_0000;
localparam logic [63:0] SIZE_4M      = 64'h0000_0000_0040_0000;

class walk_scoreboard;
  ptw_pkg::res_t expected_q[$];
  int errors;

  logic [63:0] cr3;
  bit long_mode, pae, pse, nx_en, nx_ok;

  walk_level_e level;
  logic [51:0] entry_addr;
  logic [47:0] vaddr;
  bit acc_w, acc_u, acc_nx, wide, entry_unc;

  function new();
    errors = 0;
    cr3 = '0;
    long_mode = 0; pae = 0; pse = 0; nx_en = 0; nx_ok = 0;
    level = WALK_IDLE;
    entry_addr = '0;
    vaddr = '0;
    acc_w = 0; acc_u = 0; acc_nx = 0;
    wide = 1;
    entry_unc = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [63:0] v);
    case (idx)
      ptw_pkg::CFG_CR3: cr3 = v;
      ptw_pkg::CFG_LM:  long_mode = v[0];
      ptw_pkg::CFG_PAE: pae = v[0];
      ptw_pkg::CFG_PSE: pse = v[0];
      ptw_pkg::CFG_NXE: nx_en = v[0];
      ptw_pkg::CFG_NXA: nx_ok = v[0];
      default: ;
    endcase
  endfunction

  function bit walk_idle();
    return level == WALK_IDLE;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Appends one predicted result at the tail of the expected queue.
  function void expect_result(ptw_pkg::res_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  function ptw_pkg::res_t make_result(logic [2:0] kind, logic [51:0] addr, logic [63:0] data,
                                      bit wd, bit unc);
    ptw_pkg::res_t r;
    r = '0;
    r.kind = kind;
    r.mem_address = addr;
    r.mem_data = data;
    r.wide_access = wd;
    r.uncacheable = unc;
    return r;
  endfunction

  function int push_fault(logic [2:0] kind);
    ptw_pkg::res_t r;
    r = make_result(kind, entry_addr, {16'b0, vaddr}, wide, 1'b0);
    r.last = 1'b1;
    expect_result(r);
    level = WALK_IDLE;
    return 1;
  endfunction

  function int push_fill(logic [63:0] frame, logic [63:0] size, logic [1:0] psz,
                         bit unc, bit g, bit pat);
    ptw_pkg::res_t r;
    r = make_result(ptw_pkg::KIND_FILL, frame[51:0], {16'b0, vaddr} & ~(size - 64'd1),
                    wide, unc);
    r.page_size = psz;
    r.writable = acc_w;
    r.user_access = acc_u;
    r.no_exec = acc_nx;
    r.global_page = g;
    r.pat_bit = pat;
    r.last = 1'b1;
    expect_result(r);
    level = WALK_IDLE;
    return 1;
  endfunction

  // Predicts the results of one accepted item; returns how many it causes.
  function int note_input(bit op, logic [47:0] va, logic [63:0] rd);
    logic [63:0] pte, nxt;
    ptw_pkg::res_t rd_req, wb;
    walk_level_e lv, nlv;
    bit w, u, pcd, a, ps, g, nx, bad, dowr;
    nlv = WALK_IDLE;
    if (op == ptw_pkg::OP_START) begin
      if (level != WALK_IDLE) return 0;
      vaddr = va;
      acc_w = 0; acc_u = 0; acc_nx = 0;
      wide = 1;
      if (long_mode) begin
        level = PML4;
        nxt = (cr3 & FRAME40) + (64'(va[47:39]) << 3);
      end else if (pae) begin
        level = PAE_PDPT;
        nxt = (cr3 & PAE_DIR_BASE) + (64'(va[31:30]) << 3);
      end else begin
        wide = 0;
        level = pse ? LEG_PSE_PD : LEG_PD;
        nxt = (cr3 & FRAME20) + (64'(va[31:22]) << 2);
      end
      entry_addr = nxt[51:0];
      entry_unc = cr3[4];
      rd_req = make_result(ptw_pkg::KIND_READ, entry_addr, 64'd0, wide, entry_unc);
      rd_req.last = 1'b1;
      expect_result(rd_req);
      return 1;
    end

    if (level == WALK_IDLE) return 0;
    lv = level;
    pte = wide ? rd : {32'b0, rd[31:0]};
    w = pte[1]; u = pte[2]; pcd = pte[4]; a = pte[5];
    ps = pte[7]; g = pte[8]; nx = pte[63];
    bad = nx && !(nx_ok && nx_en);

    // NX beats not-present; the PAE PDPT and legacy levels skip the NX check
    if (bad && (lv inside {PML4, PDPT, PD_LONG, PT_LONG, PAE_PD, PAE_PT}))
      return push_fault(ptw_pkg::KIND_NX);
    if (!pte[0]) return push_fault(ptw_pkg::KIND_NP);

    case (lv)
      PML4, PAE_PD, LEG_PSE_PD, LEG_PD: begin
        acc_w = w;
        acc_u = u;
      end
      PAE_PDPT: ;
      default: begin
        acc_w = acc_w && w;
        acc_u = acc_u && u;
      end
    endcase
    if (lv == PML4) acc_nx = nx;
    dowr = (lv != PAE_PDPT) && !a;

    case (lv)
      PML4: begin
        nxt = (pte & FRAME40) + (64'(vaddr[38:30]) << 3);
        nlv = PDPT;
      end
      PDPT, PAE_PDPT: begin
        nxt = (pte & FRAME40) + (64'(vaddr[29:21]) << 3);
        nlv = (lv == PDPT) ? PD_LONG : PAE_PD;
      end
      PD_LONG, PAE_PD: begin
        if (ps)
          return push_fill(pte & FRAME2M, SIZE_2M, ptw_pkg::PSZ_2M, pcd, g, pte[12]);
        nxt = (pte & FRAME40) + (64'(vaddr[20:12]) << 3);
        nlv = (lv == PD_LONG) ? PT_LONG : PAE_PT;
      end
      PT_LONG: return push_fill(pte & FRAME40, SIZE_4K, ptw_pkg::PSZ_4K, pcd, g, pte[12]);
      PAE_PT:  return push_fill(pte & FRAME40, SIZE_4K, ptw_pkg::PSZ_4K, pcd, g, pte[7]);
      LEG_PSE_PD: begin
        if (ps)
          return push_fill({24'b0, pte[20:13], pte[31:22], 22'b0}, SIZE_4M, ptw_pkg::PSZ_4M,
                           pcd, g, pte[12]);
        nxt = (pte & FRAME20) + (64'(vaddr[21:12]) << 2);
        nlv = LEG_PT;
      end
      LEG_PD: begin
        nxt = (pte & FRAME20) + (64'(vaddr[21:12]) << 2);
        nlv = LEG_PT;
      end
      default: return push_fill(pte & FRAME20, SIZE_4K, ptw_pkg::PSZ_4K, pcd, g, pte[7]);
    endcase

    rd_req = make_result(ptw_pkg::KIND_READ, nxt[51:0], 64'd0, wide, pcd);
    rd_req.last = !dowr;
    expect_result(rd_req);
    if (dowr) begin
      wb = make_result(ptw_pkg::KIND_WRITE, entry_addr, pte | 64'h20, wide, entry_unc);
      wb.last = 1'b1;
      expect_result(wb);
    end
    entry_addr = nxt[51:0];
    entry_unc = pcd;
    level = nlv;
    return dowr ? 2 : 1;
  endfunction

  function void cmp(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(ptw_pkg::res_t got);
    ptw_pkg::res_t want;
    if (expected_q.size() == 0) begin
      $display("%0t unexpected result: expected none actual kind %0d addr %h data %h",
               $time, got.kind, got.mem_address, got.mem_data);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    cmp("kind",        64'(want.kind),        64'(got.kind));
    cmp("mem_address", 64'(want.mem_address), 64'(got.mem_address));
    cmp("mem_data",    want.mem_data,         got.mem_data);
    cmp("wide_access", 64'(want.wide_access), 64'(got.wide_access));
    cmp("uncacheable", 64'(want.uncacheable), 64'(got.uncacheable));
    cmp("page_size",   64'(want.page_size),   64'(got.page_size));
    cmp("writable",    64'(want.writable),    64'(got.writable));
    cmp("user_access", 64'(want.user_access), 64'(got.user_access));
    cmp("no_exec",     64'(want.no_exec),     64'(got.no_exec));
    cmp("global_page", 64'(want.global_page), 64'(got.global_page));
    cmp("pat_bit",     64'(want.pat_bit),     64'(got.pat_bit));
    cmp("last",        64'(want.last),        64'(got.last));
  endfunction
endclass

module testbench;

  localparam int PHASES       = 10;
  localparam int RANDOM_ITEMS = 800;   // items that produce results
  localparam int LONG_HOLD    = 200;   // receiver back-pressure stretch, cycles
  localparam int SETTLE       = 6;     // margin before cfg writes
  localparam int WATCHDOG     = 3000000;

  logic clk = 1'b0;
  logic rst_n;

  logic        cfg_write_enable;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  logic        in_valid, in_ready, in_opcode;
  logic [47:0] in_virtual_address;
  logic [63:0] in_read_data;

  logic        out_valid, out_ready;
  logic [2:0]  out_kind;
  logic [51:0] out_mem_address;
  logic [63:0] out_mem_data;
  logic        out_wide_access, out_uncacheable;
  logic [1:0]  out_page_size;
  logic        out_writable, out_user_access, out_no_exec;
  logic        out_global_page, out_pat_bit, out_last;

  walk_scoreboard sb;
  ptw_pkg::res_t  seen_result;

  // Knobs shared by the sender, the receiver and the phase sequencer.
  bit sender_fast, receiver_fast, hold_request;
  int last_results;   // results caused by the most recently accepted item

  always #5 clk = ~clk;

  x86_page_table_walk_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write_enable   (cfg_write_enable),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_virtual_address (in_virtual_address),
    .in_read_data       (in_read_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_mem_address    (out_mem_address),
    .out_mem_data       (out_mem_data),
    .out_wide_access    (out_wide_access),
    .out_uncacheable    (out_uncacheable),
    .out_page_size      (out_page_size),
    .out_writable       (out_writable),
    .out_user_access    (out_user_access),
    .out_no_exec        (out_no_exec),
    .out_global_page    (out_global_page),
    .out_pat_bit        (out_pat_bit),
    .out_last           (out_last)
  );

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [47:0] rand_va();
    return {16'($urandom), $urandom};
  endfunction

  // Table entry biased toward walks that go deep: mostly present, NX rare,
  // large-page bit now and then; everything else random.
  function automatic logic [63:0] walk_entry();
    logic [63:0] e;
    e = rand_word();
    e[0]  = ($urandom_range(0, 9) != 0);
    e[63] = ($urandom_range(0, 7) == 0);
    e[7]  = ($urandom_range(0, 3) == 0);
    return e;
  endfunction

  // Offer one item and hold it until accepted, then hand it to the predictor.
  // Valid stays high on return so a back-to-back item needs no extra edge.
  task automatic send_item(input bit op, input logic [47:0] va, input logic [63:0] rd);
    int gap;
    gap = sender_fast ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_virtual_address <= va;
    in_read_data <= rd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    last_results = sb.note_input(op, va, rd);
  endtask

  // Registers change only with the block idle: stop offering, drain every
  // expected result, let the pipe settle, then write all six.
  task automatic program_regs(input logic [63:0] cr3, input bit lm, input bit pae,
                              input bit pse, input bit nxe, input bit nxa);
    logic [63:0] vals [NUM_REGS];
    logic [63:0] junk;
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    // single-bit registers get junk in the upper bits; only bit 0 counts
    vals[ptw_pkg::CFG_CR3] = cr3;
    junk = rand_word();
    vals[ptw_pkg::CFG_LM]  = {junk[63:1], lm};
    junk = rand_word();
    vals[ptw_pkg::CFG_PAE] = {junk[63:1], pae};
    junk = rand_word();
    vals[ptw_pkg::CFG_PSE] = {junk[63:1], pse};
    junk = rand_word();
    vals[ptw_pkg::CFG_NXE] = {junk[63:1], nxe};
    junk = rand_word();
    vals[ptw_pkg::CFG_NXA] = {junk[63:1], nxa};
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_write_enable <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(i[2:0], vals[i]);
    end
    cfg_write_enable <= 1'b0;
  endtask

  task automatic program_random();
    logic [63:0] cr3;
    int mode;
    case ($urandom_range(0, 3))
      0: cr3 = '0;
      1: cr3 = '1;
      default: cr3 = rand_word();
    endcase
    mode = $urandom_range(0, 3);   // 0 long, 1 PAE, 2 legacy+PSE, 3 legacy
    program_regs(cr3, mode == 0,
                 (mode == 1) || (mode == 0 && $urandom_range(0, 1) == 1),
                 (mode == 2) || (mode != 3 && $urandom_range(0, 1) == 1),
                 $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1);
  endtask

  // Directed walks: field extremes, every result kind, each mode, wrong-phase
  // items, NX over not-present, CR3 cache-disable on the root read.
  task automatic directed_walks();
    // long mode, CR3 all ones (root uncacheable), NX usable
    program_regs('1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
    send_item(ptw_pkg::OP_START, '1, '0);
    send_item(ptw_pkg::OP_RESPONSE, '1, 64'hFFFF_FFFF_FFFF_FFFF);  // NX allowed, A set
    send_item(ptw_pkg::OP_RESPONSE, '0, 64'h7FFF_FFFF_FFFF_FFDF);  // A clear: write-back
    send_item(ptw_pkg::OP_RESPONSE, '0, 64'h000F_FFFF_FFE0_1187);  // 2M fill with G and PAT
    send_item(ptw_pkg::OP_START, '0, '1);
    send_item(ptw_pkg::OP_RESPONSE, '0, '0);                       // not present

    // long mode, NX not enabled
    program_regs(64'h0000_0000_0000_1010, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
    send_item(ptw_pkg::OP_RESPONSE, '0, 64'h1);                    // response while idle
    send_item(ptw_pkg::OP_START, 48'h1234_5678_9ABC, '0);
    send_item(ptw_pkg::OP_START, 48'hFEDC_BA98_7654, '0);          // start during a walk
    send_item(ptw_pkg::OP_RESPONSE, '0, 64'h8000_0000_0000_0000);  // NX wins over not present
    send_item(ptw_pkg::OP_START, 48'h8000_0000_0000, '0);
    send_item(ptw_pkg::OP_RESPONSE, '0, 64'h0000_0000_0000_0007);
    send_item(ptw_pkg::OP_RESPONSE, '0, 64'h0000_0000_0000_0027);
    send_item(ptw_pkg::OP_RESPONSE, '0, 64'h0000_0000_0000_0015);  // writable drops
    send_item(ptw_pkg::OP_RESPONSE, '0, 64'h000F_FFFF_FFFF_F107);  // 4K fill

    // PAE: PDPT entry only checked for presence
    program_regs('0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_item(ptw_pkg::OP_START, 48'h0000_C000_0000, '0);
    send_item(ptw_pkg::OP_RESPONSE, '0, 64'h8000_0000_0000_0001);
    send_item(ptw_pkg::OP_RESPONSE, '0, 64'h0000_0000_0020_1093);  // 2M fill, uncacheable
    send_item(ptw_pkg::OP_START, '1, '0);
    send_item(ptw_pkg::OP_RESPONSE, '0, 64'h0000_0000_0000_0001);
    send_item(ptw_pkg::OP_RESPONSE, '0, 64'h0000_0000_0000_0003);
    send_item(ptw_pkg::OP_RESPONSE, '0, 64'h8000_0000_0000_0001);  // NX fault at the PT

    // legacy with PSE: 4M page from a narrow entry, then a 4K walk
    program_regs(64'h0000_0000_FFFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
    send_item(ptw_pkg::OP_START, '1, '0);
    send_item(ptw_pkg::OP_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ptw_pkg::OP_START, 48'h0000_0040_1000, '0);
    send_item(ptw_pkg::OP_RESPONSE, '0, 64'hFFFF_FFFF_0000_0005);  // PD, not writable
    send_item(ptw_pkg::OP_RESPONSE, '0, 64'h0000_0000_FFFF_F1B7);  // PT fill
  endtask

  // Mostly well-formed walks with random content; the rest is noise that
  // lands in whatever phase the walk happens to be in.
  task automatic run_phase(input int n);
    int useful;
    int pick;
    useful = 0;
    while (useful < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 12)
        send_item(1'($urandom_range(0, 1)), rand_va(), rand_word());
      else if (sb.walk_idle())
        send_item(ptw_pkg::OP_START, rand_va(), rand_word());
      else
        send_item(ptw_pkg::OP_RESPONSE, rand_va(), walk_entry());
      if (last_results > 0) useful++;
    end
    // close any open walk with a not-present entry before the next setup
    while (!sb.walk_idle())
      send_item(ptw_pkg::OP_RESPONSE, rand_va(), rand_word() & ~64'h1);
  endtask

  // Result sink: random stall before each item, occasionally a long hold.
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = receiver_fast ? 0 : $urandom_range(0, 11);
      if (hold_request) begin
        stall = LONG_HOLD;
        hold_request = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  // Result monitor: values sampled at the edge are the pre-edge ones.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_result.kind        = out_kind;
      seen_result.mem_address = out_mem_address;
      seen_result.mem_data    = out_mem_data;
      seen_result.wide_access = out_wide_access;
      seen_result.uncacheable = out_uncacheable;
      seen_result.page_size   = out_page_size;
      seen_result.writable    = out_writable;
      seen_result.user_access = out_user_access;
      seen_result.no_exec     = out_no_exec;
      seen_result.global_page = out_global_page;
      seen_result.pat_bit     = out_pat_bit;
      seen_result.last        = out_last;
      sb.check_result(seen_result);
    end
  end

  initial begin
    #(WATCHDOG);
    $display("%0t timeout", $time);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_write_enable = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_opcode = 1'b0;
    in_virtual_address = '0;
    in_read_data = '0;
    out_ready = 1'b0;
    sender_fast = 0;
    receiver_fast = 0;
    hold_request = 0;
    last_results = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_walks();

    for (int ph = 0; ph < PHASES; ph++) begin
      sender_fast = ($urandom_range(0, 3) == 0);
      receiver_fast = ($urandom_range(0, 3) == 0);
      program_random();
      if (ph == 2) begin
        // receiver holds off while the sender streams: fills the record queue
        hold_request = 1;
        sender_fast = 1;
        receiver_fast = 0;
      end
      run_phase(RANDOM_ITEMS / PHASES);
    end

    in_valid <= 1'b0;
    for (int k = 0; k < 5000 && sb.pending() != 0; k++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0t %0d expected results never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/ptw_pkg.sv
design/ptw_front.sv
design/ptw_queue.sv
design/ptw_back.sv
design/x86_page_table_walk_unit.sv
sim/testbench.sv
